/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define CDQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");

// Check a property at every edge, reset included.
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

/* hdl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared widths, codes and defaults for the circular deque engine.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 8;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

endpackage

/* hdl/cdq_store.sv */
// ----------------------------------------------------------------------------
// cdq_store
// Element store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cdq_store #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [cdq_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr_a,
    input  logic [AW-1:0]               rd_addr_b,
    output logic [cdq_pkg::DATA_W-1:0]  rd_data_a,
    output logic [cdq_pkg::DATA_W-1:0]  rd_data_b
);

    logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* hdl/circular_deque_engine.sv */
// ----------------------------------------------------------------------------
// circular_deque_engine
// Double-ended queue over a circular element store.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one action (push front, push rear, pop front,
//   pop rear) and its data; m_* channel returns one result per action:
//   status, front and rear elements, count and the empty/full flags.
//   cfg_we/cfg_wdata write the capacity; a write also empties the queue.
//   Write it only while no action is in flight.
// Sequence:
//   An action passes through ST_IDLE and ST_READ: in ST_IDLE the accept
//   updates the pointers and writes the store; in ST_READ the registered
//   store reads of the new front and rear go into the output register
//   once it is free. A new action is not taken until ST_READ has passed
//   on the result of the last one, since s_ready is low in ST_READ.
// Reset:
//   Synchronous, active low. Queue is empty, capacity is 128 (clamped to
//   DEPTH). Store contents are not cleared; only held entries are read.
// Stall:
//   While a result waits on m_ready, the next action is accepted and its
//   result is held back until the output register frees.
// ----------------------------------------------------------------------------
module circular_deque_engine #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]          cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cdq_pkg::ACT_W-1:0]          s_action,
    input  logic signed [cdq_pkg::DATA_W-1:0]  s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cdq_pkg::STAT_W-1:0]         m_status,
    output logic signed [cdq_pkg::DATA_W-1:0]  m_front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]  m_rear_value,
    output logic [cdq_pkg::CNT_W-1:0]          m_count,
    output logic                               m_is_empty,
    output logic                               m_is_full
);

    localparam int AW      = $clog2(DEPTH);
    localparam int PW      = (AW < cdq_pkg::CNT_W) ? AW : cdq_pkg::CNT_W;
    localparam int CAP_MAX = (DEPTH < 255) ? DEPTH : 255;
    localparam logic [cdq_pkg::CNT_W-1:0] CAP_MAX_C = cdq_pkg::CNT_W'(CAP_MAX);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t                       state_reg;
    logic [cdq_pkg::CNT_W-1:0]    cap_reg;
    logic [PW-1:0]                head_reg, tail_reg;
    logic [cdq_pkg::CNT_W-1:0]    count_reg;
    logic [cdq_pkg::STAT_W-1:0]   status_reg;
    logic [cdq_pkg::DATA_W-1:0]   wdata_reg;
    logic                         fwd_front_reg, fwd_rear_reg;

    logic                         m_valid_reg;
    logic [cdq_pkg::STAT_W-1:0]   m_status_reg;
    logic [cdq_pkg::DATA_W-1:0]   m_front_reg, m_rear_reg;
    logic [cdq_pkg::CNT_W-1:0]    m_count_reg;
    logic                         m_empty_reg, m_full_reg;

    logic [cdq_pkg::CNT_W-1:0]    cap_eff;
    logic [PW-1:0]                cap_last;
    logic [PW-1:0]                head_next, tail_next, waddr;
    logic [cdq_pkg::CNT_W-1:0]    count_next;
    logic [cdq_pkg::STAT_W-1:0]   status_next;
    logic                         we;
    logic                         accept;
    logic [cdq_pkg::DATA_W-1:0]   rd_front, rd_rear;

    // Clamp the configured capacity into 1..DEPTH (at most 255).
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = cdq_pkg::CNT_W'(1);
        end else if (cap_reg > CAP_MAX_C) begin
            cap_eff = CAP_MAX_C;
        end else begin
            cap_eff = cap_reg;
        end
        cap_last = PW'(cap_eff - cdq_pkg::CNT_W'(1));
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_we;
    assign accept  = s_valid && s_ready;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = cdq_pkg::STAT_DONE;
        waddr       = '0;
        we          = 1'b0;
        unique case (cdq_pkg::action_t'(s_action))
            cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
                if (count_reg >= cap_eff) begin
                    status_next = cdq_pkg::STAT_OVERFLOW;
                end else if (count_reg == '0) begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = cdq_pkg::CNT_W'(1);
                    we         = 1'b1;
                end else if (cdq_pkg::action_t'(s_action) == cdq_pkg::ACT_PUSH_FRONT) begin
                    head_next  = (head_reg == '0) ? cap_last : head_reg - PW'(1);
                    waddr      = head_next;
                    count_next = count_reg + cdq_pkg::CNT_W'(1);
                    we         = 1'b1;
                end else begin
                    tail_next  = (tail_reg == cap_last) ? '0 : tail_reg + PW'(1);
                    waddr      = tail_next;
                    count_next = count_reg + cdq_pkg::CNT_W'(1);
                    we         = 1'b1;
                end
            end
            cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
                if (count_reg == '0) begin
                    status_next = cdq_pkg::STAT_UNDERFLOW;
                end else if (count_reg == cdq_pkg::CNT_W'(1)) begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end else if (cdq_pkg::action_t'(s_action) == cdq_pkg::ACT_POP_FRONT) begin
                    head_next  = (head_reg == cap_last) ? '0 : head_reg + PW'(1);
                    count_next = count_reg - cdq_pkg::CNT_W'(1);
                end else begin
                    tail_next  = (tail_reg == '0) ? cap_last : tail_reg - PW'(1);
                    count_next = count_reg - cdq_pkg::CNT_W'(1);
                end
            end
            default: begin
                status_next = cdq_pkg::STAT_DONE;
            end
        endcase
    end

    cdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (accept && we),
        .wr_addr   (AW'(waddr)),
        .wr_data   (s_data),
        .rd_en     (accept),
        .rd_addr_a (AW'(head_next)),
        .rd_addr_b (AW'(tail_next)),
        .rd_data_a (rd_front),
        .rd_data_b (rd_rear)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= cdq_pkg::CAP_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // A capacity write blocks the input, so it never meets an accept.
            if (cfg_we) begin
                cap_reg   <= cfg_wdata;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        head_reg      <= head_next;
                        tail_reg      <= tail_next;
                        count_reg     <= count_next;
                        status_reg    <= status_next;
                        wdata_reg     <= s_data;
                        // The read misses this cycle's write: forward it.
                        fwd_front_reg <= we && (waddr == head_next);
                        fwd_rear_reg  <= we && (waddr == tail_next);
                        state_reg     <= ST_READ;
                    end
                end
                ST_READ: begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_count_reg  <= count_reg;
                        m_empty_reg  <= (count_reg == '0);
                        m_full_reg   <= (count_reg == cap_eff);
                        if (count_reg == '0) begin
                            m_front_reg <= '0;
                            m_rear_reg  <= '0;
                        end else begin
                            m_front_reg <= fwd_front_reg ? wdata_reg : rd_front;
                            m_rear_reg  <= fwd_rear_reg  ? wdata_reg : rd_rear;
                        end
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_front_value = m_front_reg;
    assign m_rear_value  = m_rear_reg;
    assign m_count       = m_count_reg;
    assign m_is_empty    = m_empty_reg;
    assign m_is_full     = m_full_reg;

endmodule

/* hdl/cdq_checker.sv */
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               s_ready,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [cdq_pkg::STAT_W-1:0]         m_status,
    input  logic signed [cdq_pkg::DATA_W-1:0]  m_front_value,
    input  logic signed [cdq_pkg::DATA_W-1:0]  m_rear_value,
    input  logic [cdq_pkg::CNT_W-1:0]          m_count,
    input  logic                               m_is_empty,
    input  logic                               m_is_full
);

    // A stalled result keeps its count and status.
    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status);
    endproperty

    // An empty flag comes with a zero count, and an empty queue shows zero elements.
    property p_empty_zero;
        m_valid && m_is_empty |->
            m_count == '0 && m_front_value == '0 && m_rear_value == '0;
    endproperty

    // A refused push leaves the queue full; a refused pop leaves it empty.
    property p_refusal;
        m_valid |-> (m_status != cdq_pkg::STAT_OVERFLOW || m_is_full) &&
                    (m_status != cdq_pkg::STAT_UNDERFLOW || m_is_empty);
    endproperty

    `CDQ_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)

    `CDQ_ASSERT(a_empty_zero, aclk, aresetn, p_empty_zero)

    `CDQ_ASSERT(a_refusal, aclk, aresetn, p_refusal)

    // No transaction is accepted while a configuration write is taken.
    `CDQ_ASSERT(a_cfg_excl, aclk, aresetn, cfg_we |-> !s_ready)

    // Reset drops any pending result.
    `CDQ_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid)

endmodule

bind circular_deque_engine cdq_checker u_cdq_checker (.*);

/* dv/circular_deque_engine_tb.sv */
// ----------------------------------------------------------------------------
// circular_deque_engine_tb
// Self-checking bench for the circular deque engine. A mirror of the deque
// (ring, head, tail, count, capacity) predicts the result of every accepted
// action. A monitor compares each returned transaction with the oldest
// prediction. Traffic is directed corner cases followed by biased random
// phases over several capacities, under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module circular_deque_engine_tb;

    localparam int RING_DEPTH = cdq_pkg::DEPTH_DEFAULT;

    typedef struct {
        cdq_pkg::status_t                   status;
        logic signed [cdq_pkg::DATA_W-1:0]  front;
        logic signed [cdq_pkg::DATA_W-1:0]  rear;
        logic [cdq_pkg::CNT_W-1:0]          count;
        logic                               empty;
        logic                               full;
    } deque_reply_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_we;
    logic [cdq_pkg::CNT_W-1:0]          cfg_wdata;
    logic                               s_valid;
    logic                               s_ready;
    logic [cdq_pkg::ACT_W-1:0]          s_action;
    logic signed [cdq_pkg::DATA_W-1:0]  s_data;
    logic                               m_valid;
    logic                               m_ready;
    logic [cdq_pkg::STAT_W-1:0]         m_status;
    logic signed [cdq_pkg::DATA_W-1:0]  m_front_value;
    logic signed [cdq_pkg::DATA_W-1:0]  m_rear_value;
    logic [cdq_pkg::CNT_W-1:0]          m_count;
    logic                               m_is_empty;
    logic                               m_is_full;

    // Mirror of the deque state
    logic signed [cdq_pkg::DATA_W-1:0]  mirror_ring [RING_DEPTH];
    int                                 mirror_head;
    int                                 mirror_tail;
    int                                 mirror_held;
    logic [cdq_pkg::CNT_W-1:0]          mirror_cap;

    deque_reply_t              predicted_replies [$];
    int                        mismatch_cnt;
    int                        burst_left;
    int                        hold_req;
    int                        hold_left;
    int                        stall_mode;
    int                        stall_left;
    int                        stall_tick;

    circular_deque_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_count       (m_count),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Apply one action to the mirror and return the reply it should produce
    function automatic deque_reply_t deque_apply(
        input cdq_pkg::action_t act,
        input logic signed [cdq_pkg::DATA_W-1:0] val);
        deque_reply_t r;
        int lim;
        lim = (mirror_cap == 0) ? 1 : ((mirror_cap > RING_DEPTH) ? RING_DEPTH : mirror_cap);
        r.status = cdq_pkg::STAT_DONE;
        if (act == cdq_pkg::ACT_PUSH_FRONT || act == cdq_pkg::ACT_PUSH_REAR) begin
            if (mirror_held >= lim) begin
                r.status = cdq_pkg::STAT_OVERFLOW;
            end else if (mirror_held == 0) begin
                mirror_head = 0;
                mirror_tail = 0;
                mirror_ring[0] = val;
                mirror_held = 1;
            end else if (act == cdq_pkg::ACT_PUSH_FRONT) begin
                mirror_head = (mirror_head == 0) ? lim - 1 : mirror_head - 1;
                mirror_ring[mirror_head] = val;
                mirror_held++;
            end else begin
                mirror_tail = (mirror_tail == lim - 1) ? 0 : mirror_tail + 1;
                mirror_ring[mirror_tail] = val;
                mirror_held++;
            end
        end else begin
            if (mirror_held == 0) begin
                r.status = cdq_pkg::STAT_UNDERFLOW;
            end else if (mirror_held == 1) begin
                mirror_head = 0;
                mirror_tail = 0;
                mirror_held = 0;
            end else if (act == cdq_pkg::ACT_POP_FRONT) begin
                mirror_head = (mirror_head == lim - 1) ? 0 : mirror_head + 1;
                mirror_held--;
            end else begin
                mirror_tail = (mirror_tail == 0) ? lim - 1 : mirror_tail - 1;
                mirror_held--;
            end
        end
        r.front = (mirror_held != 0) ? mirror_ring[mirror_head] : '0;
        r.rear  = (mirror_held != 0) ? mirror_ring[mirror_tail] : '0;
        r.count = mirror_held[cdq_pkg::CNT_W-1:0];
        r.empty = (mirror_held == 0);
        r.full  = (mirror_held == lim);
        return r;
    endfunction

    // Send one action in bursts separated by random gaps
    task automatic send_action(input cdq_pkg::action_t act,
                               input logic signed [cdq_pkg::DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_action <= act;
        s_data   <= val;
        do @(posedge aclk); while (!s_ready);
        predicted_replies.push_back(deque_apply(act, val));
    endtask

    // Hold off the sender until every reply is back, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (predicted_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [cdq_pkg::CNT_W-1:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        mirror_cap  = cap;
        mirror_head = 0;
        mirror_tail = 0;
        mirror_held = 0;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [cdq_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::action_t pick_action(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT;
    endfunction

    // Reset capacity: underflow on empty, extreme values, pop of the last element
    task automatic test_reset_capacity_ops();
        send_action(cdq_pkg::ACT_POP_FRONT, 32'sd5);
        send_action(cdq_pkg::ACT_POP_REAR, -32'sd5);
        send_action(cdq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000);
        send_action(cdq_pkg::ACT_PUSH_REAR, 32'sh7FFF_FFFF);
        send_action(cdq_pkg::ACT_PUSH_FRONT, '0);
        send_action(cdq_pkg::ACT_PUSH_REAR, -32'sd1);
        send_action(cdq_pkg::ACT_POP_FRONT, '0);
        send_action(cdq_pkg::ACT_POP_REAR, '0);
        send_action(cdq_pkg::ACT_POP_FRONT, '0);
        send_action(cdq_pkg::ACT_POP_REAR, '0);
        send_action(cdq_pkg::ACT_POP_FRONT, '0);
    endtask

    // Smallest capacities, zero acting as one, and wrap at a small capacity
    task automatic test_capacity_edges();
        write_capacity(8'd1);
        send_action(cdq_pkg::ACT_PUSH_REAR, 32'sh1234_5678);
        send_action(cdq_pkg::ACT_PUSH_FRONT, 32'sh0BAD_F00D);
        send_action(cdq_pkg::ACT_POP_FRONT, '0);
        write_capacity(8'd0);
        send_action(cdq_pkg::ACT_PUSH_FRONT, 32'sh5555_AAAA);
        send_action(cdq_pkg::ACT_PUSH_REAR, 32'shAAAA_5555);
        send_action(cdq_pkg::ACT_POP_REAR, '0);
        write_capacity(8'd3);
        send_action(cdq_pkg::ACT_PUSH_FRONT, 32'sd11);
        send_action(cdq_pkg::ACT_PUSH_FRONT, 32'sd22);
        send_action(cdq_pkg::ACT_PUSH_REAR, 32'sd33);
        send_action(cdq_pkg::ACT_PUSH_REAR, 32'sd44);
        send_action(cdq_pkg::ACT_POP_REAR, '0);
        send_action(cdq_pkg::ACT_POP_FRONT, '0);
    endtask

    // Long receiver hold-off while the sender keeps offering actions
    task automatic test_output_backpressure();
        write_capacity(8'd16);
        hold_req = 80;
        repeat (30) send_action(pick_action(60), pick_data());
        wait_idle();
    endtask

    task automatic run_phase(input logic [cdq_pkg::CNT_W-1:0] cap, input int n_items);
        int seg_left;
        int push_pct;
        seg_left = 0;
        push_pct = 50;
        write_capacity(cap);
        repeat (n_items) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                seg_left = $urandom_range(10, 200);
            end
            seg_left--;
            send_action(pick_action(push_pct), pick_data());
        end
    endtask

    task automatic test_random_traffic();
        run_phase(8'd255, 300);
        run_phase(8'd7, 150);
        run_phase(8'd2, 80);
        run_phase(8'd0, 40);
        run_phase(8'($urandom_range(3, 127)), 150);
        run_phase(8'd128, 300);
        run_phase(8'($urandom_range(129, 254)), 100);
    endtask

    // Receiver: long hold-offs on request, otherwise a rotating stall pattern
    initial begin
        m_ready <= 1'b0;
        hold_left  = 0;
        stall_left = 0;
        stall_mode = 0;
        stall_tick = 0;
        forever begin
            @(posedge aclk);
            stall_tick++;
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(16, 96);
                end
                stall_left--;
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 9) < 6);
                    default: m_ready <= (stall_tick % 3 == 0);
                endcase
            end
        end
    end

    // Compare each returned transaction with the oldest prediction
    always @(posedge aclk) begin
        deque_reply_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transaction: st=%0d fr=%0d rr=%0d cnt=%0d e=%0b f=%0b",
                             m_status, m_front_value, m_rear_value, m_count,
                             m_is_empty, m_is_full);
            end else begin
                exp_r = predicted_replies.pop_front();
                if (m_status !== exp_r.status || m_front_value !== exp_r.front ||
                    m_rear_value !== exp_r.rear || m_count !== exp_r.count ||
                    m_is_empty !== exp_r.empty || m_is_full !== exp_r.full) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"reply mismatch: exp st=%0d fr=%0d rr=%0d cnt=%0d e=%0b f=%0b",
                                  " | got st=%0d fr=%0d rr=%0d cnt=%0d e=%0b f=%0b"},
                                 exp_r.status, exp_r.front, exp_r.rear, exp_r.count,
                                 exp_r.empty, exp_r.full,
                                 m_status, m_front_value, m_rear_value, m_count,
                                 m_is_empty, m_is_full);
                end
            end
        end
    end

    initial begin
        mismatch_cnt = 0;
        burst_left   = 0;
        hold_req     = 0;
        mirror_head  = 0;
        mirror_tail  = 0;
        mirror_held  = 0;
        mirror_cap   = cdq_pkg::CAP_RESET;
        foreach (mirror_ring[i]) mirror_ring[i] = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_action  <= cdq_pkg::ACT_PUSH_FRONT;
        s_data    <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_capacity_ops();
        test_capacity_edges();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && predicted_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_store.sv
hdl/circular_deque_engine.sv
hdl/cdq_checker.sv
dv/circular_deque_engine_tb.sv
